### design/bops_pkg.sv
// ----------------------------------------------------------------------------
// bops_pkg
// Shared types and codes for the bounded ordered pin set: request and
// response payloads, request kinds, status codes and the controller command.
// ----------------------------------------------------------------------------
package bops_pkg;

	// default capacity of the set
	localparam int MAX_PINS_DEF = 32;

	// field widths
	localparam int KIND_W   = 2;
	localparam int ID_W     = 32;
	localparam int SLOT_W   = 5;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 6;
	localparam int VALUE_W  = 31;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

	// response status codes
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd5;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd6;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd7;

	// request payload
	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [ID_W-1:0]   pin_id;
		logic [SLOT_W-1:0]        slot;
	} req_t;

	// response payload
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                is_pinned;
		logic [COUNT_W-1:0]  pin_count;
		logic [VALUE_W-1:0]  entry_value;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} bops_cmd_t;

endpackage

### design/bops_ctrl.sv
// ----------------------------------------------------------------------------
// bops_ctrl
// Request sequencer: takes a request, lets the datapath compare it against every
// cell into a registered match vector, then commits the update and the response
// once the response register is free.
// ----------------------------------------------------------------------------
module bops_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output bops_pkg::bops_cmd_t cmd
);
	import bops_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   rsp_valid_q;
	logic   commit;

	// commit when the response register is empty or being drained
	assign commit      = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = commit;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_nx = S_EXEC;
			end
			S_EXEC: begin
				if (commit) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state and response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (commit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

### design/bops_dp.sv
// ----------------------------------------------------------------------------
// bops_dp
// Pin set datapath: a row of id cells kept in insertion order, a parallel
// compare into a registered match vector, the update logic that appends or
// removes and closes the gap, and the response register.
// ----------------------------------------------------------------------------
module bops_dp #(
	parameter int MAX_PINS = bops_pkg::MAX_PINS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bops_pkg::bops_cmd_t cmd,
	input  bops_pkg::req_t      req,
	output bops_pkg::rsp_t      rsp
);
	import bops_pkg::*;

	localparam int CNT_W = $clog2(MAX_PINS + 1);
	localparam int SW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	// cell row and count
	logic [VALUE_W-1:0] cells_q [MAX_PINS];
	logic [VALUE_W-1:0] cells_up [MAX_PINS];
	logic [CNT_W-1:0]   count_q;

	// captured request and match vector
	logic [KIND_W-1:0]  kind_s1;
	logic               id_ok_s1;
	logic [VALUE_W-1:0] id_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [MAX_PINS-1:0] match_s1;

	// execute stage
	logic               present;
	logic               full;
	logic [CNT_W-1:0]   pos;
	logic               do_remove;
	logic               do_append;
	logic [CNT_W-1:0]   count_nx;
	logic [SW-1:0]      slot_x;
	logic               filled;
	logic [VALUE_W-1:0] read_val;
	logic [CNT_W+COUNT_W-1:0] count_wide;
	rsp_t               rsp_nx;
	rsp_t               rsp_q;

	// next-higher neighbor of each cell, used when closing a gap
	for (genvar g = 0; g < MAX_PINS; g++) begin : g_up
		if (g < MAX_PINS - 1) begin : g_mid
			assign cells_up[g] = cells_q[g + 1];
		end else begin : g_top
			assign cells_up[g] = cells_q[g];
		end
	end

	// capture request and compare against every filled cell
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1  <= req.kind;
			id_ok_s1 <= !req.pin_id[ID_W-1] && (req.pin_id != '0);
			id_s1    <= req.pin_id[VALUE_W-1:0];
			slot_s1  <= req.slot;
			for (int i = 0; i < MAX_PINS; i++) begin
				match_s1[i] <= (cells_q[i] == req.pin_id[VALUE_W-1:0]) &&
				               (CNT_W'(i) < count_q);
			end
		end
	end

	// locate the match and read the requested slot
	always_comb begin
		present = |match_s1;
		full    = (count_q == CNT_W'(MAX_PINS));
		pos     = '0;
		for (int i = MAX_PINS - 1; i >= 0; i--) begin
			if (match_s1[i]) pos = CNT_W'(i);
		end
		slot_x   = SW'(slot_s1);
		filled   = (slot_x < SW'(count_q)) && (slot_x < SW'(MAX_PINS));
		read_val = '0;
		for (int i = 0; i < MAX_PINS; i++) begin
			if (slot_x == SW'(i)) read_val = cells_q[i];
		end
	end

	// decide the outcome of the request
	always_comb begin
		do_remove = 1'b0;
		do_append = 1'b0;
		rsp_nx    = '0;
		if (kind_s1 == KIND_READ) begin
			if (filled) begin
				rsp_nx.status      = ST_PRESENT;
				rsp_nx.is_pinned   = 1'b1;
				rsp_nx.entry_value = read_val;
			end else begin
				rsp_nx.status = ST_EMPTY;
			end
		end else if (!id_ok_s1) begin
			rsp_nx.status = ST_INVALID;
		end else if (kind_s1 == KIND_QUERY) begin
			rsp_nx.status    = present ? ST_PRESENT : ST_ABSENT;
			rsp_nx.is_pinned = present;
		end else if (present && kind_s1 == KIND_TOGGLE) begin
			do_remove     = 1'b1;
			rsp_nx.status = ST_REMOVED;
		end else if (present) begin
			rsp_nx.status    = ST_DUPLICATE;
			rsp_nx.is_pinned = 1'b1;
		end else if (full) begin
			rsp_nx.status = ST_FULL;
		end else begin
			do_append        = 1'b1;
			rsp_nx.status    = ST_ADDED;
			rsp_nx.is_pinned = 1'b1;
		end
		if (do_remove) count_nx = count_q - CNT_W'(1);
		else if (do_append) count_nx = count_q + CNT_W'(1);
		else count_nx = count_q;
		count_wide       = (CNT_W + COUNT_W)'(count_nx);
		rsp_nx.pin_count = count_wide[COUNT_W-1:0];
	end

	// cell row update: shift down above the removed cell, or append at the end
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < MAX_PINS; i++) begin
				if (do_remove && (CNT_W'(i) >= pos)) cells_q[i] <= cells_up[i];
				else if (do_append && (CNT_W'(i) == count_q)) cells_q[i] <= id_s1;
			end
			rsp_q <= rsp_nx;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nx;
		end
	end

	assign rsp = rsp_q;

endmodule

### design/bounded_ordered_pin_set_top.sv
// ----------------------------------------------------------------------------
// bounded_ordered_pin_set_top
// Bounded insertion-ordered set of positive ids with query, toggle, add and
// slot read requests.
// ----------------------------------------------------------------------------
// In the cycle a request is accepted its id is compared against all MAX_PINS
// cells at once and the hits are registered as a match vector; then the match
// is encoded and, once the response register is free, the cell row is updated
// (append at the end, or removal with every later cell shifting down one place)
// and the response register is loaded. A new request is taken only once the
// previous one has been committed, so no request is accepted while another is
// still in progress; a response left waiting holds the following request in
// its update cycle. The cells have no reset and no clearing pass: only the
// entry count is cleared, and only cells below it are ever used. pin_count
// reports the count modulo 64.
module bounded_ordered_pin_set_top #(
	parameter int MAX_PINS = bops_pkg::MAX_PINS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bops_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bops_pkg::rsp_t rsp
);
	import bops_pkg::*;

	bops_cmd_t cmd;

	// request sequencer
	bops_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// cell row, compare and update
	bops_dp #(
		.MAX_PINS (MAX_PINS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
